@@ sv/tsp_pkg.sv @@
// Package for the tone sequence player: item types, codes, constants and the step ROM.
`default_nettype none

package tsp_pkg;

   // Command codes carried by an input item
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_STOP  = 2'd2;

   // Melody codes
   localparam logic [2:0] MEL_WELCOME = 3'd0;
   localparam logic [2:0] MEL_GRANTED = 3'd1;
   localparam logic [2:0] MEL_CLOSING = 3'd2;
   localparam logic [2:0] MEL_ALARM   = 3'd3;
   localparam logic [2:0] MEL_WARNING = 3'd4;

   localparam int MELODY_COUNT = 5;
   localparam int ROM_ROWS     = 3;

   // Longest melody that is played; longer melodies are cut
   localparam int MAX_STEPS = 4;

   // Default width of the millisecond down counter
   localparam int TIME_WIDTH = 16;

   // Durations and gaps in the ROM all fit in this many bits
   localparam int ROM_TIME_BITS = 9;

   typedef struct packed {
      logic [1:0]  command;
      logic [2:0]  melody;
      logic        repeat_enable;
      logic [15:0] repeat_pause;
   } tsp_item_type;

   typedef struct packed {
      logic [15:0] tone_freq;
      logic        busy_res;
      logic [2:0]  current_step;
   } tsp_result_type;

   typedef struct packed {
      logic [15:0]              freq;
      logic [ROM_TIME_BITS-1:0] dur;
      logic [ROM_TIME_BITS-1:0] gap;
   } tsp_step_type;

   // Number of steps of each melody; unknown codes give zero
   function automatic logic [2:0] tsp_tune_len(input logic [2:0] mel);
      logic [2:0] len;
      case (mel)
         MEL_WELCOME: len = 3'd3;
         MEL_GRANTED: len = 3'd2;
         MEL_CLOSING: len = 3'd2;
         MEL_ALARM:   len = 3'd3;
         MEL_WARNING: len = 3'd2;
         default:     len = 3'd0;
      endcase
      return len;
   endfunction

   // Step ROM: frequency, tone duration and following gap
   function automatic tsp_step_type tsp_step_rom(input logic [2:0] mel, input logic [1:0] row);
      tsp_step_type s;
      s = '0;
      case (mel)
         MEL_WELCOME: begin
            case (row)
               2'd0:    s = '{16'd523, 9'd180, 9'd200};
               2'd1:    s = '{16'd659, 9'd180, 9'd200};
               2'd2:    s = '{16'd784, 9'd180, 9'd0};
               default: s = '0;
            endcase
         end
         MEL_GRANTED: begin
            case (row)
               2'd0:    s = '{16'd784, 9'd160, 9'd180};
               2'd1:    s = '{16'd987, 9'd160, 9'd0};
               default: s = '0;
            endcase
         end
         MEL_CLOSING: begin
            case (row)
               2'd0:    s = '{16'd392, 9'd220, 9'd180};
               2'd1:    s = '{16'd349, 9'd220, 9'd0};
               default: s = '0;
            endcase
         end
         MEL_ALARM: begin
            case (row)
               2'd0, 2'd1: s = '{16'd1046, 9'd300, 9'd200};
               2'd2:       s = '{16'd1046, 9'd300, 9'd0};
               default:    s = '0;
            endcase
         end
         MEL_WARNING: begin
            case (row)
               2'd0:    s = '{16'd330, 9'd380, 9'd180};
               2'd1:    s = '{16'd294, 9'd380, 9'd0};
               default: s = '0;
            endcase
         end
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

@@ sv/tsp_req_if.sv @@
// Request channel interface: valid/ready handshake carrying one command item.
`default_nettype none

interface tsp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [2:0]  melody;
   logic        repeat_enable;
   logic [15:0] repeat_pause;

   modport source (output valid, output command, output melody, output repeat_enable,
                   output repeat_pause, input ready);
   modport sink   (input valid, input command, input melody, input repeat_enable,
                   input repeat_pause, output ready);
endinterface

`default_nettype wire

@@ sv/tsp_rsp_if.sv @@
// Response channel interface: valid/ready handshake carrying one result item.
`default_nettype none

interface tsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] tone_freq;
   logic        busy_res;
   logic [2:0]  current_step;

   modport source (output valid, output tone_freq, output busy_res, output current_step,
                   input ready);
   modport sink   (input valid, input tone_freq, input busy_res, input current_step,
                   output ready);
endinterface

`default_nettype wire

@@ sv/tsp_input_stage.sv @@
// Input register stage: captures one request item and holds it until the engine takes it.
`default_nettype none

module tsp_input_stage (
   input  wire logic            clock,
   input  wire logic            reset,
   tsp_req_if.sink              req_bus,
   input  wire logic            take,
   output tsp_pkg::tsp_item_type item,
   output logic                 item_valid
);

   logic                  valid_ff, valid_in;
   tsp_pkg::tsp_item_type item_ff, item_in;
   logic                  load;

   // Free slot when empty or when the held item leaves this cycle
   assign req_bus.ready = !valid_ff || take;
   assign load          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in              = 1'b1;
         item_in.command       = req_bus.command;
         item_in.melody        = req_bus.melody;
         item_in.repeat_enable = req_bus.repeat_enable;
         item_in.repeat_pause  = req_bus.repeat_pause;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item       = item_ff;
   assign item_valid = valid_ff;

endmodule

`default_nettype wire

@@ sv/tsp_engine.sv @@
// Player state and single-pass update: one item per cycle while advance is high, result taken after the update.
`default_nettype none

module tsp_engine #(
   parameter int TIME_WIDTH = tsp_pkg::TIME_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire tsp_pkg::tsp_item_type  item,
   output tsp_pkg::tsp_result_type     result
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_TONE  = 2'd1;
   localparam logic [1:0] PH_PAUSE = 2'd2;

   logic [1:0]            phase_ff, phase_in;
   logic [TIME_WIDTH-1:0] wait_left_ff, wait_left_in;
   logic [2:0]            step_index_ff, step_index_in;
   logic [2:0]            melody_sel_ff, melody_sel_in;
   logic [2:0]            sequence_length_ff, sequence_length_in;
   logic                  repeat_flag_ff, repeat_flag_in;
   logic [TIME_WIDTH-1:0] repeat_wait_ff, repeat_wait_in;
   logic [15:0]           tone_reg_ff, tone_reg_in;

   logic [TIME_WIDTH-1:0] repeat_sat;
   logic [2:0]            start_len;
   logic [2:0]            rom_mel;
   logic [1:0]            rom_row;
   tsp_pkg::tsp_step_type step;
   logic                  playing;

   // Repeat pause clipped to the counter width
   generate
      if (TIME_WIDTH >= 16) begin : g_rep_wide
         assign repeat_sat = TIME_WIDTH'(item.repeat_pause);
      end else begin : g_rep_sat
         assign repeat_sat = ((item.repeat_pause >> TIME_WIDTH) != 16'd0) ?
                             {TIME_WIDTH{1'b1}} : item.repeat_pause[TIME_WIDTH-1:0];
      end
   endgenerate

   // Melody length, cut to the step limit
   always_comb begin
      start_len = tsp_pkg::tsp_tune_len(item.melody);
      if (int'(start_len) > tsp_pkg::MAX_STEPS) begin
         start_len = 3'(tsp_pkg::MAX_STEPS);
      end
   end

   // ROM lookup for the step in progress
   assign rom_mel = (int'(melody_sel_ff) < tsp_pkg::MELODY_COUNT) ? melody_sel_ff : 3'd0;
   assign rom_row = (int'(step_index_ff) < tsp_pkg::ROM_ROWS) ? step_index_ff[1:0] : 2'd0;
   assign step    = tsp_pkg::tsp_step_rom(rom_mel, rom_row);

   assign playing = (phase_ff == PH_TONE) || (phase_ff == PH_PAUSE);

   // Next state for the item in hand
   always_comb begin
      phase_in           = phase_ff;
      wait_left_in       = wait_left_ff;
      step_index_in      = step_index_ff;
      melody_sel_in      = melody_sel_ff;
      sequence_length_in = sequence_length_ff;
      repeat_flag_in     = repeat_flag_ff;
      repeat_wait_in     = repeat_wait_ff;
      tone_reg_in        = tone_reg_ff;
      case (item.command)
         tsp_pkg::CMD_TICK: begin
            if (playing && sequence_length_ff != 3'd0) begin
               if (wait_left_ff > TIME_WIDTH'(1)) begin
                  wait_left_in = wait_left_ff - TIME_WIDTH'(1);
               end else if (phase_ff == PH_PAUSE) begin
                  if (step_index_ff >= sequence_length_ff) begin
                     // melody done: repeat after the pause or go idle
                     tone_reg_in = 16'd0;
                     if (repeat_flag_ff) begin
                        step_index_in = 3'd0;
                        wait_left_in  = repeat_wait_ff;
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end else begin
                     tone_reg_in  = step.freq;
                     phase_in     = PH_TONE;
                     wait_left_in = TIME_WIDTH'(step.dur);
                  end
               end else begin
                  tone_reg_in   = 16'd0;
                  phase_in      = PH_PAUSE;
                  wait_left_in  = TIME_WIDTH'(step.gap);
                  step_index_in = step_index_ff + 3'd1;
               end
            end
         end
         tsp_pkg::CMD_START: begin
            if (int'(item.melody) < tsp_pkg::MELODY_COUNT) begin
               melody_sel_in      = item.melody;
               sequence_length_in = start_len;
               step_index_in      = 3'd0;
               repeat_flag_in     = item.repeat_enable;
               repeat_wait_in     = repeat_sat;
               phase_in           = PH_PAUSE;
               wait_left_in       = '0;
            end
         end
         tsp_pkg::CMD_STOP: begin
            tone_reg_in        = 16'd0;
            phase_in           = PH_IDLE;
            sequence_length_in = 3'd0;
         end
         default: begin
            // unknown command: state holds
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         wait_left_ff       <= '0;
         step_index_ff      <= 3'd0;
         melody_sel_ff      <= 3'd0;
         sequence_length_ff <= 3'd0;
         repeat_flag_ff     <= 1'b0;
         repeat_wait_ff     <= '0;
         tone_reg_ff        <= 16'd0;
      end else if (advance) begin
         phase_ff           <= phase_in;
         wait_left_ff       <= wait_left_in;
         step_index_ff      <= step_index_in;
         melody_sel_ff      <= melody_sel_in;
         sequence_length_ff <= sequence_length_in;
         repeat_flag_ff     <= repeat_flag_in;
         repeat_wait_ff     <= repeat_wait_in;
         tone_reg_ff        <= tone_reg_in;
      end
   end

   // Result reflects the state after this item
   assign result.tone_freq    = tone_reg_in;
   assign result.busy_res     = (phase_in == PH_TONE) || (phase_in == PH_PAUSE);
   assign result.current_step = step_index_in;

`ifndef SYNTHESIS
   a_busy_has_len: assert property (@(posedge clock) disable iff (reset)
      playing |-> sequence_length_ff != 3'd0)
      else $error("active phase with empty melody");
   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      playing |-> step_index_ff <= sequence_length_ff)
      else $error("step index past melody length");
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> tone_reg_ff == 16'd0)
      else $error("tone sounding while idle");
   a_stop_silences: assert property (@(posedge clock) disable iff (reset)
      (advance && item.command == tsp_pkg::CMD_STOP) |=> (tone_reg_ff == 16'd0 && !playing))
      else $error("stop did not silence");
`endif

endmodule

`default_nettype wire

@@ sv/tone_sequence_player_core.sv @@
// Top level of the tone sequence player: input stage, engine and result register.
//
// Usage:
//   req_bus carries one item per handshake: a tick (one millisecond), a start
//   (melody, repeat flag, repeat pause) or a stop. rsp_bus returns exactly one
//   result item per request item, in order: the tone frequency now sounding
//   (0 is silence), the busy flag and the step in progress, all as they stand
//   after that item.
//   A request accepted into the input register passes through the engine into
//   the result register.
//   Throughput: one item per cycle while rsp_bus takes results, set by the single
//   pass of the state update (a compare, a decrement and a step ROM lookup) between the input register
//   and the result register.
//   Reset (synchronous, active high) empties both registers, sets the player
//   idle and silent with all counters at zero.
//   When the receiver stalls, the result register holds its item, the input
//   register keeps one more item, and req_bus.ready drops until rsp_bus moves.
`default_nettype none

module tone_sequence_player_core #(
   parameter int TIME_WIDTH = tsp_pkg::TIME_WIDTH
) (
   input  wire logic clock,
   input  wire logic reset,
   tsp_req_if.sink   req_bus,
   tsp_rsp_if.source rsp_bus
);

   tsp_pkg::tsp_item_type   item;
   logic                    item_valid;
   logic                    take;
   tsp_pkg::tsp_result_type result;
   tsp_pkg::tsp_result_type result_ff;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Item moves on when the result register is free or drains this cycle
   assign take = item_valid && (!rsp_valid_ff || rsp_bus.ready);

   tsp_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .take       (take),
      .item       (item),
      .item_valid (item_valid)
   );

   tsp_engine #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (take),
      .item    (item),
      .result  (result)
   );

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take) begin
         result_ff <= result;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.tone_freq    = result_ff.tone_freq;
   assign rsp_bus.busy_res     = result_ff.busy_res;
   assign rsp_bus.current_step = result_ff.current_step;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the tone sequence player: directed table, then random melodies.
`timescale 1ns / 100ps

module testbench;

   // Codes the package leaves unnamed: the spare command and the invalid melodies
   localparam logic [1:0] CMD_SPARE   = 2'd3;
   localparam logic [2:0] MEL_SPARE5  = 3'd5;
   localparam logic [2:0] MEL_SPARE6  = 3'd6;
   localparam logic [2:0] MEL_SPARE7  = 3'd7;
   localparam int         STALL_LIMIT = 2000;
   localparam int         PRINT_LIMIT = 50;

   typedef enum logic [1:0] {PLAY_IDLE, PLAY_TONE, PLAY_GAP} play_phase_type;

   typedef struct {
      tsp_pkg::tsp_item_type   item;
      tsp_pkg::tsp_result_type want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tsp_req_if req_bus ();
   tsp_rsp_if rsp_bus ();

   tone_sequence_player_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // Step table of the five melodies: frequency, tone time and following silence
   logic [15:0] rom_hz     [0:4][0:2] = '{'{523, 659, 784}, '{784, 987, 0}, '{392, 349, 0},
                                          '{1046, 1046, 1046}, '{330, 294, 0}};
   logic [15:0] rom_on_ms  [0:4][0:2] = '{'{180, 180, 180}, '{160, 160, 0}, '{220, 220, 0},
                                          '{300, 300, 300}, '{380, 380, 0}};
   logic [15:0] rom_off_ms [0:4][0:2] = '{'{200, 200, 0}, '{180, 0, 0}, '{180, 0, 0},
                                          '{200, 200, 0}, '{180, 0, 0}};
   logic [2:0]  rom_steps  [0:4]      = '{3, 2, 2, 3, 2};

   // Player state as predicted
   play_phase_type play_phase  = PLAY_IDLE;
   logic [15:0]    wait_ms     = '0;
   logic [2:0]     step_idx    = '0;
   logic [2:0]     tune_sel    = '0;
   logic [2:0]     tune_len    = '0;
   logic           loop_on     = 1'b0;
   logic [15:0]    loop_gap_ms = '0;
   logic [15:0]    tone_now    = '0;

   tsp_pkg::tsp_result_type expected_tones[$];
   dir_row_type             dir_table[$];

   // Side band riding along with the item: a typed-in result overrides the prediction
   logic                    pin_on  = 1'b0;
   tsp_pkg::tsp_result_type pin_val = '0;

   int          errors     = 0;
   int          rsp_count  = 0;
   int          sent_items = 0;
   int          burst_left = 0;
   int          idle_run   = 0;
   logic [9:0]  stall_cnt  = '0;

   task automatic report(input string msg);
      if (errors < PRINT_LIMIT)
         $display("tb: result %0d: %0s", rsp_count, msg);
      errors++;
   endtask

   // Advance the player by one item and return the result it shows afterwards
   task automatic play_step(input tsp_pkg::tsp_item_type it,
                            output tsp_pkg::tsp_result_type res);
      logic [2:0] m;
      logic [1:0] row;
      logic [2:0] len;
      m   = (tune_sel < 3'd5) ? tune_sel : 3'd0;
      row = (step_idx < 3'd3) ? step_idx[1:0] : 2'd0;
      case (it.command)
         tsp_pkg::CMD_TICK: begin
            if (play_phase != PLAY_IDLE && tune_len != 0) begin
               if (wait_ms > 1) begin
                  wait_ms = wait_ms - 16'd1;
               end else if (play_phase == PLAY_GAP) begin
                  if (step_idx >= tune_len) begin
                     // melody over: go silent, then stop or wait out the repeat pause
                     tone_now = '0;
                     if (loop_on) begin
                        step_idx = '0;
                        wait_ms  = loop_gap_ms;
                     end else begin
                        play_phase = PLAY_IDLE;
                     end
                  end else begin
                     tone_now   = rom_hz[m][row];
                     play_phase = PLAY_TONE;
                     wait_ms    = rom_on_ms[m][row];
                  end
               end else begin
                  tone_now   = '0;
                  play_phase = PLAY_GAP;
                  wait_ms    = rom_off_ms[m][row];
                  step_idx   = step_idx + 3'd1;
               end
            end
         end
         tsp_pkg::CMD_START: begin
            if (it.melody <= tsp_pkg::MEL_WARNING) begin
               len         = rom_steps[it.melody];
               tune_len    = (len > tsp_pkg::MAX_STEPS) ? 3'(tsp_pkg::MAX_STEPS) : len;
               tune_sel    = it.melody;
               step_idx    = '0;
               loop_on     = it.repeat_enable;
               loop_gap_ms = it.repeat_pause;
               play_phase  = PLAY_GAP;
               wait_ms     = '0;
            end
         end
         tsp_pkg::CMD_STOP: begin
            tone_now   = '0;
            play_phase = PLAY_IDLE;
            tune_len   = '0;
         end
         default: ;
      endcase
      res.tone_freq    = tone_now;
      res.busy_res     = (play_phase != PLAY_IDLE);
      res.current_step = step_idx;
   endtask

   function automatic tsp_pkg::tsp_item_type any_item();
      tsp_pkg::tsp_item_type it;
      it.command       = 2'($urandom_range(0, 3));
      it.melody        = 3'($urandom_range(0, 7));
      it.repeat_enable = 1'($urandom_range(0, 1));
      it.repeat_pause  = 16'($urandom);
      return it;
   endfunction

   function automatic dir_row_type dir_row(input logic [1:0] cmd, input logic [2:0] mel,
                                           input logic rep, input logic [15:0] pause,
                                           input logic [15:0] freq, input logic busy,
                                           input logic [2:0] step);
      dir_row_type r;
      r.item = '{cmd, mel, rep, pause};
      r.want = '{freq, busy, step};
      return r;
   endfunction

   // Offer one item in bursts with random gaps; returns once it is accepted
   task automatic push_item(input tsp_pkg::tsp_item_type it, input logic pinned,
                            input tsp_pkg::tsp_result_type want);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
         burst_left = $urandom_range(1, 64);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      sent_items++;
      req_bus.valid         <= 1'b1;
      req_bus.command       <= it.command;
      req_bus.melody        <= it.melody;
      req_bus.repeat_enable <= it.repeat_enable;
      req_bus.repeat_pause  <= it.repeat_pause;
      pin_on                <= pinned;
      pin_val               <= want;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic random_item(input tsp_pkg::tsp_item_type it);
      push_item(it, 1'b0, '0);
   endtask

   // Hold the sender off until every outstanding result has come back
   task automatic hold_until_quiet();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_tones.size() != 0);
   endtask

   // Receiver stall pattern: free flow, random, sparse holes, every other pair
   always @(posedge clock) begin
      stall_cnt <= stall_cnt + 1'b1;
      case (stall_cnt[9:8])
         2'd0:    rsp_bus.ready <= 1'b1;
         2'd1:    rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         2'd2:    rsp_bus.ready <= (stall_cnt[2:0] != 3'd5) && (stall_cnt[2:0] != 3'd6);
         default: rsp_bus.ready <= stall_cnt[1];
      endcase
   end

   // Result check, prediction on acceptance and the watchdog
   always @(posedge clock) begin : watch
      tsp_pkg::tsp_result_type got;
      tsp_pkg::tsp_result_type want;
      tsp_pkg::tsp_result_type predicted;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.tone_freq, rsp_bus.busy_res, rsp_bus.current_step};
            if (expected_tones.size() == 0) begin
               report("result with no item pending");
            end else begin
               want = expected_tones.pop_front();
               if (got.tone_freq !== want.tone_freq)
                  report($sformatf("tone_freq got %0d want %0d", got.tone_freq,
                                   want.tone_freq));
               if (got.busy_res !== want.busy_res)
                  report($sformatf("busy_res got %0d want %0d", got.busy_res,
                                   want.busy_res));
               if (got.current_step !== want.current_step)
                  report($sformatf("current_step got %0d want %0d", got.current_step,
                                   want.current_step));
            end
            rsp_count++;
         end
         if (req_bus.valid && req_bus.ready) begin
            play_step('{req_bus.command, req_bus.melody, req_bus.repeat_enable,
                        req_bus.repeat_pause}, predicted);
            expected_tones.push_back(pin_on ? pin_val : predicted);
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_run = 0;
         else
            idle_run++;
         if (idle_run >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin : stimulus
      tsp_pkg::tsp_item_type it;
      int                    run;
      int                    rand_items;
      req_bus.valid         = 1'b0;
      req_bus.command       = tsp_pkg::CMD_TICK;
      req_bus.melody        = tsp_pkg::MEL_WELCOME;
      req_bus.repeat_enable = 1'b0;
      req_bus.repeat_pause  = '0;
      rsp_bus.ready         = 1'b0;
      rand_items            = 0;

      // Directed: idle behavior, ignored codes, restarts, stop, pause extremes
      dir_table.push_back(dir_row(tsp_pkg::CMD_TICK, tsp_pkg::MEL_WELCOME, 1'b0, 16'h0000,
                                  16'd0, 1'b0, 3'd0));
      dir_table.push_back(dir_row(CMD_SPARE, MEL_SPARE7, 1'b1, 16'hFFFF,
                                  16'd0, 1'b0, 3'd0));
      dir_table.push_back(dir_row(tsp_pkg::CMD_STOP, tsp_pkg::MEL_WELCOME, 1'b0, 16'h0000,
                                  16'd0, 1'b0, 3'd0));
      dir_table.push_back(dir_row(tsp_pkg::CMD_START, MEL_SPARE7, 1'b1, 16'hFFFF,
                                  16'd0, 1'b0, 3'd0));
      dir_table.push_back(dir_row(tsp_pkg::CMD_START, MEL_SPARE5, 1'b0, 16'h0001,
                                  16'd0, 1'b0, 3'd0));
      dir_table.push_back(dir_row(tsp_pkg::CMD_START, tsp_pkg::MEL_WELCOME, 1'b1, 16'hFFFF,
                                  16'd0, 1'b1, 3'd0));
      dir_table.push_back(dir_row(tsp_pkg::CMD_TICK, MEL_SPARE7, 1'b1, 16'hFFFF,
                                  16'd523, 1'b1, 3'd0));
      dir_table.push_back(dir_row(tsp_pkg::CMD_STOP, tsp_pkg::MEL_WELCOME, 1'b0, 16'h0000,
                                  16'd0, 1'b0, 3'd0));
      dir_table.push_back(dir_row(tsp_pkg::CMD_TICK, tsp_pkg::MEL_WELCOME, 1'b0, 16'h0000,
                                  16'd0, 1'b0, 3'd0));
      dir_table.push_back(dir_row(tsp_pkg::CMD_START, tsp_pkg::MEL_GRANTED, 1'b0, 16'h0000,
                                  16'd0, 1'b1, 3'd0));
      dir_table.push_back(dir_row(tsp_pkg::CMD_TICK, tsp_pkg::MEL_WELCOME, 1'b0, 16'h0000,
                                  16'd784, 1'b1, 3'd0));
      dir_table.push_back(dir_row(tsp_pkg::CMD_TICK, tsp_pkg::MEL_WELCOME, 1'b0, 16'h0000,
                                  16'd784, 1'b1, 3'd0));
      dir_table.push_back(dir_row(CMD_SPARE, tsp_pkg::MEL_WARNING, 1'b1, 16'hFFFF,
                                  16'd784, 1'b1, 3'd0));
      dir_table.push_back(dir_row(tsp_pkg::CMD_START, MEL_SPARE6, 1'b1, 16'h5A5A,
                                  16'd784, 1'b1, 3'd0));
      // a start keeps the tone that is sounding until the next tick
      dir_table.push_back(dir_row(tsp_pkg::CMD_START, tsp_pkg::MEL_ALARM, 1'b1, 16'h0000,
                                  16'd784, 1'b1, 3'd0));
      dir_table.push_back(dir_row(tsp_pkg::CMD_TICK, tsp_pkg::MEL_WELCOME, 1'b0, 16'h0000,
                                  16'd1046, 1'b1, 3'd0));
      dir_table.push_back(dir_row(tsp_pkg::CMD_START, tsp_pkg::MEL_WARNING, 1'b0, 16'h0001,
                                  16'd1046, 1'b1, 3'd0));
      dir_table.push_back(dir_row(tsp_pkg::CMD_TICK, tsp_pkg::MEL_WELCOME, 1'b0, 16'h0000,
                                  16'd330, 1'b1, 3'd0));
      dir_table.push_back(dir_row(tsp_pkg::CMD_START, tsp_pkg::MEL_CLOSING, 1'b1, 16'h8000,
                                  16'd330, 1'b1, 3'd0));
      dir_table.push_back(dir_row(tsp_pkg::CMD_TICK, tsp_pkg::MEL_WELCOME, 1'b0, 16'hA5A5,
                                  16'd392, 1'b1, 3'd0));
      dir_table.push_back(dir_row(tsp_pkg::CMD_STOP, MEL_SPARE7, 1'b1, 16'hFFFF,
                                  16'd0, 1'b0, 3'd0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i])
         push_item(dir_table[i].item, 1'b1, dir_table[i].want);
      hold_until_quiet();

      // Random: melodies driven by tick runs, with noise mixed in
      while (rand_items < 850) begin
         if ($urandom_range(0, 9) < 7) begin
            it               = any_item();
            it.command       = tsp_pkg::CMD_START;
            it.melody        = 3'($urandom_range(tsp_pkg::MEL_WELCOME, tsp_pkg::MEL_WARNING));
            case ($urandom_range(0, 3))
               0:       it.repeat_pause = 16'd0;
               1:       it.repeat_pause = 16'd1;
               2:       it.repeat_pause = 16'($urandom_range(2, 40));
               default: it.repeat_pause = 16'($urandom);
            endcase
            random_item(it);
            rand_items++;
            run = ($urandom_range(0, 4) < 2) ? $urandom_range(400, 800)
                                              : $urandom_range(1, 200);
            if (rand_items + run > 850)
               run = 850 - rand_items;
            repeat (run) begin
               it = any_item();
               if ($urandom_range(0, 199) != 0)
                  it.command = tsp_pkg::CMD_TICK;
               random_item(it);
               rand_items++;
            end
            if ($urandom_range(0, 2) == 0) begin
               it         = any_item();
               it.command = tsp_pkg::CMD_STOP;
               random_item(it);
               rand_items++;
            end
         end else begin
            repeat ($urandom_range(1, 6)) begin
               random_item(any_item());
               rand_items++;
            end
         end
         if ($urandom_range(0, 29) == 0)
            hold_until_quiet();
      end

      // Drain and let the pipeline settle
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_tones.size() != 0);
      repeat (4) @(posedge clock);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
